/* rtl/plc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants
// Word layouts and fixed-point constants for the piecewise-linear calibrator.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int unsigned DATA_W = 32;
	// Quotient bits: the fraction lies in (0, 5.0] Q16.16, at most 327680.
	localparam int unsigned QUO_W = 19;
	// One segment step, 5.0 in Q16.16.
	localparam logic [DATA_W-1:0] STEP_Q16 = 32'd327680;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_CONVERT = 1'b1
	} plc_mode_t;

	// Side data that travels with a reading through the divider.
	typedef struct packed {
		logic              hit;
		logic [2:0]        seg;
		logic [DATA_W-1:0] raw;
		logic [DATA_W-1:0] base;
	} plc_tag_t;

endpackage

/* rtl/plc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_divider: pipelined restoring divider
// Compute (off * 5 * 65536) / wid for off <= wid, one quotient bit a stage.
// ----------------------------------------------------------------------------
module plc_divider (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            off,
	input  logic [31:0]            wid,
	input  plc_pkg::plc_tag_t      in_tag,
	output logic                   out_valid,
	output logic [plc_pkg::QUO_W-1:0] quo,
	output plc_pkg::plc_tag_t      out_tag
);
	import plc_pkg::*;

	logic              vld_s [0:QUO_W];
	logic [31:0]       rem_s [0:QUO_W];
	logic [31:0]       wid_s [0:QUO_W];
	logic [2:0]        mlo_s [0:QUO_W];
	logic [QUO_W-1:0]  quo_s [0:QUO_W];
	plc_tag_t          tag_s [0:QUO_W];
	logic [34:0]       m5;

	// off * 5; its top 32 bits start the remainder, low 3 bits shift in later
	assign m5 = {3'b000, off} + {1'b0, off, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= m5[34:3];
			wid_s[0] <= wid;
			mlo_s[0] <= m5[2:0];
			quo_s[0] <= '0;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int J = QUO_W - 1 - i;
		logic        nbit;
		logic [32:0] cand;
		logic [32:0] diff;
		logic        ge;

		if (J >= 16) begin : g_mbit
			assign nbit = mlo_s[i][J-16];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign cand = {rem_s[i], nbit};
		assign diff = cand - {1'b0, wid_s[i]};
		assign ge   = (cand >= {1'b0, wid_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[31:0] : cand[31:0];
				wid_s[i+1] <= wid_s[i];
				mlo_s[i+1] <= mlo_s[i];
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], ge};
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign out_tag   = tag_s[QUO_W];

endmodule

/* rtl/piecewise_linear_calibration.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_calibration: sensor linearizer
// Map a raw Q16.16 reading onto millimetres through a breakpoint table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: mode, point_index,
//   value. A load word (mode 0) writes breakpoint point_index and gives no
//   result; indexes above NUM_SEGMENTS are dropped. A convert word (mode 1)
//   gives one result word on the output channel (out_valid/out_ready):
//   converted, segment, matched.
//   Path: a convert word passes the input register, segment match,
//   offset/width, the divider's input register and its 19 quotient-bit
//   stages, one stage per quotient bit, then the output register.
//   Throughput: one word per cycle while the receiver does not stall; the divider is fully pipelined.
//   A load takes effect for every convert word accepted after it.
//   Reset clears all valid bits; the breakpoint table is undefined until
//   written. When the receiver stalls, the whole pipeline holds in place and
//   in_ready drops only while a finished word waits in the output register.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration #(
	parameter int NUM_SEGMENTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [3:0]  point_index,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] converted,
	output logic [2:0]  segment,
	output logic        matched
);
	import plc_pkg::*;

	localparam int NUM_POINTS = NUM_SEGMENTS + 1;
	localparam int PT_W       = $clog2(NUM_POINTS);

	logic                en;

	// Stage 1: input register
	logic                vld_s1;
	plc_mode_t           mode_s1;
	logic [3:0]          idx_s1;
	logic signed [31:0]  val_s1;

	// Breakpoint table, written from stage 1
	logic signed [31:0]  table_q [0:NUM_POINTS-1];
	logic [PT_W-1:0]     wr_idx;
	logic                wr_ok;

	// Segment match (stage 1 logic)
	logic                hit_c;
	logic [2:0]          seg_c;
	logic signed [31:0]  lo_c;
	logic signed [31:0]  hi_c;
	logic [31:0]         base_c;

	// Stage 2
	logic                vld_s2;
	logic signed [31:0]  raw_s2;
	logic signed [31:0]  lo_s2;
	logic signed [31:0]  hi_s2;
	logic                hit_s2;
	logic [2:0]          seg_s2;
	logic [31:0]         base_s2;

	// Stage 3
	logic                vld_s3;
	logic [31:0]         off_s3;
	logic [31:0]         wid_s3;
	plc_tag_t            tag_s3;

	// Divider output
	logic                div_vld;
	logic [QUO_W-1:0]    div_quo;
	plc_tag_t            div_tag;

	// Advance everything unless a finished word is held at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= plc_mode_t'(mode);
			idx_s1  <= point_index;
			val_s1  <= value;
		end
	end

	// Write loads at stage 1 so later converts in the same stage see them.
	assign wr_idx = PT_W'(idx_s1);
	assign wr_ok  = ({1'b0, idx_s1} <= 5'(NUM_SEGMENTS));

	always_ff @(posedge clk) begin
		if (en && vld_s1 && mode_s1 == MODE_LOAD && wr_ok) begin
			table_q[wr_idx] <= val_s1;
		end
	end

	// Test every segment; the highest match wins.
	always_comb begin
		hit_c  = 1'b0;
		seg_c  = 3'd0;
		lo_c   = table_q[0];
		hi_c   = table_q[1];
		base_c = '0;
		for (int k = 0; k < NUM_SEGMENTS; k++) begin
			if (table_q[k] < val_s1 && val_s1 <= table_q[k+1]) begin
				hit_c  = 1'b1;
				seg_c  = 3'(k);
				lo_c   = table_q[k];
				hi_c   = table_q[k+1];
				base_c = 32'(k * STEP_Q16);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1 && mode_s1 == MODE_CONVERT;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s2  <= val_s1;
			lo_s2   <= lo_c;
			hi_s2   <= hi_c;
			hit_s2  <= hit_c;
			seg_s2  <= seg_c;
			base_s2 <= base_c;

			// Offset and width are exact in 32 bits since lo < raw <= hi.
			off_s3      <= 32'(raw_s2 - lo_s2);
			wid_s3      <= 32'(hi_s2 - lo_s2);
			tag_s3.hit  <= hit_s2;
			tag_s3.seg  <= seg_s2;
			tag_s3.raw  <= raw_s2;
			tag_s3.base <= base_s2;
		end
	end

	// Unmatched words pass through the divider too; their quotient is dropped.
	plc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.off       (off_s3),
		.wid       (wid_s3),
		.in_tag    (tag_s3),
		.out_valid (div_vld),
		.quo       (div_quo),
		.out_tag   (div_tag)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			converted <= div_tag.hit ?
				div_tag.base + {{(32-QUO_W){1'b0}}, div_quo} : div_tag.raw;
			segment   <= div_tag.hit ? div_tag.seg : 3'd0;
			matched   <= div_tag.hit;
		end
	end

endmodule

/* dv/piecewise_linear_calibration_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_calibration_tb: self-checking bench for the linearizer
// Load breakpoint tables, stream readings through the block and compare each
// result word against a behavioral predictor of the segment match and scaling.
// ----------------------------------------------------------------------------
module piecewise_linear_calibration_tb;
	import plc_pkg::*;

	localparam int NSEG       = 8;
	localparam int NPTS       = NSEG + 1;
	localparam int DRAIN      = 40;
	localparam int STALL_MAX  = 20000;

	typedef struct packed {
		logic signed [31:0] converted;
		logic [2:0]         segment;
		logic               matched;
	} cal_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic mode;
	logic [3:0] point_index;
	logic signed [31:0] value;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] converted;
	logic [2:0] segment;
	logic matched;

	// predictor state: breakpoint copy
	logic signed [31:0] bp_shadow [NPTS];
	cal_result_t        pending_results [$];

	int  err_count;
	int  idle_cycles;
	int  send_idle_pct;
	int  recv_stall_pct;

	piecewise_linear_calibration #(.NUM_SEGMENTS(NSEG)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .point_index(point_index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.converted(converted), .segment(segment), .matched(matched)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Compute the calibrated word; the highest matching segment wins.
	function automatic cal_result_t linearize(logic signed [31:0] r);
		cal_result_t res;
		logic signed [63:0] lo, hi, off, wid;
		logic [63:0] frac;
		res.converted = r;
		res.segment = 3'd0;
		res.matched = 1'b0;
		for (int k = 0; k < NSEG; k++) begin
			lo = bp_shadow[k];
			hi = bp_shadow[k+1];
			if (lo < r && r <= hi) begin
				off = r - lo;
				wid = hi - lo;
				frac = (off * 64'd327680) / wid;
				res.converted = 32'(k * 327680 + frac);
				res.segment = 3'(k);
				res.matched = 1'b1;
			end
		end
		return res;
	endfunction

	// Drive one word and hold it until the block takes it.
	task automatic send_word(plc_mode_t m, logic [3:0] idx, logic signed [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		point_index <= idx;
		value <= v;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		if (m == MODE_LOAD) begin
			if (idx < NPTS) begin
				bp_shadow[idx] = v;
			end
		end else begin
			pending_results.push_back(linearize(v));
		end
		@(negedge clk);
	endtask

	task automatic load_table(logic signed [31:0] pts [NPTS]);
		for (int i = 0; i < NPTS; i++) begin
			send_word(MODE_LOAD, 4'(i), pts[i]);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Directed: ascending table, readings at and beyond both table ends, out-of-range loads.
	task automatic test_directed();
		logic signed [31:0] pts [NPTS];
		for (int i = 0; i < NPTS; i++) begin
			pts[i] = 32'sd65536 * (i * 10);
		end
		load_table(pts);
		send_word(MODE_LOAD, 4'd9, 32'sh7fff_ffff);
		send_word(MODE_LOAD, 4'd15, 32'sh8000_0000);
		send_word(MODE_CONVERT, 4'd0, pts[0]);
		send_word(MODE_CONVERT, 4'd0, pts[0] + 1);
		send_word(MODE_CONVERT, 4'd0, pts[1]);
		send_word(MODE_CONVERT, 4'd0, pts[8]);
		send_word(MODE_CONVERT, 4'd0, pts[8] + 1);
		send_word(MODE_CONVERT, 4'd15, 32'sh8000_0000);
		send_word(MODE_CONVERT, 4'd0, 32'sh7fff_ffff);
		send_word(MODE_CONVERT, 4'd0, 32'sd1966080 + 32'sd1234);
		send_word(MODE_CONVERT, 4'd0, -32'sd1);
		wait_drained();
	endtask

	// Extremes: full-range segment, flat and descending segments, overlap.
	task automatic test_extremes();
		logic signed [31:0] pts [NPTS];
		pts = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd0, -32'sd100,
			32'sd50, 32'sd40, 32'sd1000, 32'sd1001};
		load_table(pts);
		send_word(MODE_CONVERT, 4'd0, 32'sh8000_0001);
		send_word(MODE_CONVERT, 4'd0, 32'sh7fff_ffff);
		send_word(MODE_CONVERT, 4'd0, 32'sd0);
		send_word(MODE_CONVERT, 4'd0, 32'sd45);
		send_word(MODE_CONVERT, 4'd0, 32'sd1001);
		send_word(MODE_CONVERT, 4'd0, 32'sh8000_0000);
		wait_drained();
	endtask

	// Random: mostly sorted tables with random readings, some random noise.
	task automatic test_random(int n_items);
		logic signed [31:0] pts [NPTS];
		logic signed [31:0] v;
		int base, span;
		for (int i = 0; i < n_items; i++) begin
			if (i % 60 == 0) begin
				if ($urandom_range(3) == 0) begin
					for (int j = 0; j < NPTS; j++) pts[j] = $urandom;
				end else begin
					span = $urandom_range(3) == 0 ? 32'h0100_0000 : 32'h0001_0000;
					base = $signed($urandom) >>> 2;
					for (int j = 0; j < NPTS; j++) begin
						pts[j] = base;
						base = base + $urandom_range(span);
					end
				end
				load_table(pts);
			end
			case ($urandom_range(9))
				0: send_word(MODE_LOAD, 4'($urandom_range(15)), $urandom);
				1: send_word(MODE_CONVERT, 4'($urandom), $urandom);
				default: begin
					v = pts[$urandom_range(NSEG)] + $signed(32'($urandom_range(65536)))
						- 32'sd32768;
					send_word(MODE_CONVERT, 4'($urandom), v);
				end
			endcase
		end
		wait_drained();
	endtask

	// Receiver: stall at random and check each result against the oldest prediction.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cal_result_t exp_r;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word converted=%0d", converted);
					err_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (converted !== exp_r.converted) begin
						$error("converted: expected %0d, got %0d", exp_r.converted, converted);
						err_count++;
					end
					if (segment !== exp_r.segment) begin
						$error("segment: expected %0d, got %0d", exp_r.segment, segment);
						err_count++;
					end
					if (matched !== exp_r.matched) begin
						$error("matched: expected %0d, got %0d", exp_r.matched, matched);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog: abort if nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		point_index = 4'd0;
		value = 32'sd0;
		out_ready = 1'b0;
		err_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_extremes();
		test_random(100);
		send_idle_pct = 82;
		test_random(100);
		send_idle_pct = 0;
		recv_stall_pct = 82;
		test_random(100);
		send_idle_pct = 17;
		recv_stall_pct = 17;
		test_random(100);

		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
